// File: design/tmb_pkg.sv
// shared types and constants of the temporal motion blur unit
package tmb_pkg;

  localparam int ADDR_W = 19;
  localparam int CHAN_W = 8;
  localparam int SUM_W = 10;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W = 17;
  localparam int CHAN_MAX = 255;
  localparam int CHANNELS = 3;
  localparam int SOURCES = 3;

  localparam int FRAME_PIXELS_DEF = 524288;
  localparam int FRAMES_AVERAGED_DEF = 3;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_addr;
    logic [CHAN_W-1:0] in_chan0;
    logic [CHAN_W-1:0] in_chan1;
    logic [CHAN_W-1:0] in_chan2;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan0;
  } pix_t;

  typedef struct packed {
    pix_t two;
    pix_t one;
  } hist_row_t;

  typedef struct packed {
    logic valid;
    pix_t cur;
    pix_t one;
    pix_t two;
  } hist_out_t;

endpackage

// File: design/tmb_addr_wrap.sv
// address wrap pipeline: pixel address modulo the frame size in three stages
module tmb_addr_wrap #(
  parameter int FramePixels = tmb_pkg::FRAME_PIXELS_DEF,
  parameter int IdxW = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   take,
  input  tmb_pkg::in_item_t      in_item,
  output logic                   out_valid,
  output logic [IdxW-1:0]        out_idx,
  output tmb_pkg::pix_t          out_pix
);

  localparam int AW = tmb_pkg::ADDR_W;
  localparam int RecipW = AW + 1;
  localparam int RemW = (IdxW > AW) ? IdxW : AW;
  localparam logic [RecipW-1:0] Recip = RecipW'((2 ** AW) / FramePixels);
  localparam logic [RemW:0] FrameSize = (RemW + 1)'(FramePixels);

  logic                  valid1;
  logic [AW-1:0]         addr1;
  logic [AW-1:0]         quot1;
  tmb_pkg::pix_t         pix1;
  logic                  valid2;
  logic [RemW:0]         rem2;
  tmb_pkg::pix_t         pix2;
  logic                  valid3;
  logic [IdxW-1:0]       idx3;
  tmb_pkg::pix_t         pix3;

  logic [AW+RecipW-1:0]  quot_prod;
  logic [AW+RemW:0]      back_prod;
  logic [RemW:0]         rem_fix;

  assign quot_prod = in_item.pixel_addr * Recip;
  assign back_prod = quot1 * FrameSize;
  assign rem_fix   = (rem2 >= FrameSize) ? rem2 - FrameSize : rem2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (adv) begin
      valid1 <= take;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr1 <= in_item.pixel_addr;
      quot1 <= quot_prod[AW +: AW];
      pix1  <= '{chan2: in_item.in_chan2, chan1: in_item.in_chan1, chan0: in_item.in_chan0};
      rem2  <= (RemW + 1)'(addr1) - back_prod[RemW:0];
      pix2  <= pix1;
      idx3  <= rem_fix[IdxW-1:0];
      pix3  <= pix2;
    end
  end

  assign out_valid = valid3;
  assign out_idx   = idx3;
  assign out_pix   = pix3;

endmodule

// File: design/tmb_history.sv
// frame history store: read, forward, shift and write back, with clear after reset
module tmb_history #(
  parameter int FramePixels = tmb_pkg::FRAME_PIXELS_DEF,
  parameter int IdxW = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [IdxW-1:0]     in_idx,
  input  tmb_pkg::pix_t       in_pix,
  output logic                clearing,
  output tmb_pkg::hist_out_t  hist
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FramePixels - 1);

  tmb_pkg::hist_row_t mem [FramePixels];

  logic                clr_idx;
  logic [IdxW-1:0]     clr_addr;
  tmb_pkg::hist_row_t  rdata;
  logic                s1_valid;
  logic [IdxW-1:0]     s1_idx;
  tmb_pkg::pix_t       s1_cur;
  logic                s1_hit;
  tmb_pkg::hist_row_t  s1_fwd;
  tmb_pkg::hist_row_t  s1_row;
  tmb_pkg::hist_row_t  wr_row;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  tmb_pkg::hist_row_t  mem_wdata;

  assign clr_idx = (clr_addr == LastIdx);
  assign s1_row  = s1_hit ? s1_fwd : rdata;
  assign wr_row  = '{two: s1_row.one, one: s1_cur};

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = adv && s1_valid;
      mem_waddr = s1_idx;
      mem_wdata = wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_idx) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rdata <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx <= in_idx;
      s1_cur <= in_pix;
      s1_hit <= s1_valid && (s1_idx == in_idx);
      s1_fwd <= wr_row;
    end
  end

  assign hist = '{valid: s1_valid, cur: s1_cur, one: s1_row.one, two: s1_row.two};

endmodule

// File: design/tmb_blend.sv
// blend pipeline: per-channel shares (value/FramesAveraged), sums and saturation
module tmb_blend #(
  parameter int FramesAveraged = tmb_pkg::FRAMES_AVERAGED_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  tmb_pkg::hist_out_t  hist,
  output logic                out_valid,
  output tmb_pkg::out_item_t  out_item
);

  localparam int CW = tmb_pkg::CHAN_W;
  localparam int RW = tmb_pkg::RECIP_W;
  localparam logic [RW-1:0] Recip =
    RW'(((2 ** tmb_pkg::RECIP_SHIFT) + FramesAveraged - 1) / FramesAveraged);
  localparam logic [tmb_pkg::SUM_W-1:0] SatLimit = tmb_pkg::SUM_W'(tmb_pkg::CHAN_MAX);

  tmb_pkg::pix_t              src [tmb_pkg::SOURCES];
  logic [CW+RW-1:0]           prod [tmb_pkg::SOURCES][tmb_pkg::CHANNELS];
  logic [CW-1:0]              share1 [tmb_pkg::SOURCES][tmb_pkg::CHANNELS];
  logic                       valid1;
  logic [tmb_pkg::SUM_W-1:0]  sum2 [tmb_pkg::CHANNELS];
  logic                       valid2;
  logic [CW-1:0]              sat [tmb_pkg::CHANNELS];

  assign src[0] = hist.cur;
  assign src[1] = hist.one;
  assign src[2] = hist.two;

  always_comb begin
    for (int s = 0; s < tmb_pkg::SOURCES; s++) begin
      for (int c = 0; c < tmb_pkg::CHANNELS; c++) begin
        prod[s][c] = src[s][CW*c +: CW] * Recip;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < tmb_pkg::CHANNELS; c++) begin
      sat[c] = (sum2[c] > SatLimit) ? CW'(tmb_pkg::CHAN_MAX) : sum2[c][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else if (adv) begin
      valid1 <= hist.valid;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < tmb_pkg::SOURCES; s++) begin
        for (int c = 0; c < tmb_pkg::CHANNELS; c++) begin
          share1[s][c] <= prod[s][c][tmb_pkg::RECIP_SHIFT +: CW];
        end
      end
      for (int c = 0; c < tmb_pkg::CHANNELS; c++) begin
        sum2[c] <= tmb_pkg::SUM_W'(share1[0][c]) + tmb_pkg::SUM_W'(share1[1][c])
                 + tmb_pkg::SUM_W'(share1[2][c]);
      end
    end
  end

  assign out_valid = valid2;
  assign out_item  = '{out_chan0: sat[0], out_chan1: sat[1], out_chan2: sat[2]};

endmodule

// File: design/tmb_skid.sv
// output register with a skid stage
module tmb_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  input  tmb_pkg::out_item_t  up_item,
  output logic                up_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tmb_pkg::out_item_t  out_item
);

  logic                spare_valid;
  tmb_pkg::out_item_t  spare;
  logic                drain;

  assign up_ready = !spare_valid;
  assign drain    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (drain) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= up_valid;
      end
    end else if (up_valid && !spare_valid) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_item <= spare_valid ? spare : up_item;
    end else if (!spare_valid) begin
      spare <= up_item;
    end
  end

endmodule

// File: design/temporal_motion_blur_unit.sv
// top level of the temporal motion blur unit
// Averages each pixel over the current frame and the two frames before it: every output
// channel is the sum of value/FRAMES_AVERAGED (rounded down) over the three frames,
// saturated at 255. Takes one item per clock unless the output stalls or the history
// is being cleared, and gives one result per item, in order; the rate is set by the history
// memory, which has one read port and one write port and is read once and written once
// per item, with a same-address bypass so that back-to-back pixels at one address stay
// exact. After reset the history memory is cleared one row per cycle, so in_ready stays
// low until all FRAME_PIXELS rows (524288 by default) are cleared. Addresses at or beyond
// FRAME_PIXELS wrap modulo the frame size.
module temporal_motion_blur_unit #(
  parameter int FRAME_PIXELS = tmb_pkg::FRAME_PIXELS_DEF,
  parameter int FRAMES_AVERAGED = tmb_pkg::FRAMES_AVERAGED_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmb_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tmb_pkg::out_item_t  out_item
);

  localparam int IdxW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic                adv;
  logic                take;
  logic                clearing;
  logic                wrap_valid;
  logic [IdxW-1:0]     wrap_idx;
  tmb_pkg::pix_t       wrap_pix;
  tmb_pkg::hist_out_t  hist;
  logic                blend_valid;
  tmb_pkg::out_item_t  blend_item;

  assign in_ready = adv && !clearing;
  assign take     = in_valid && in_ready;

  tmb_addr_wrap #(
    .FramePixels (FRAME_PIXELS),
    .IdxW        (IdxW)
  ) u_wrap (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (take),
    .in_item   (in_item),
    .out_valid (wrap_valid),
    .out_idx   (wrap_idx),
    .out_pix   (wrap_pix)
  );

  tmb_history #(
    .FramePixels (FRAME_PIXELS),
    .IdxW        (IdxW)
  ) u_history (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (wrap_valid),
    .in_idx   (wrap_idx),
    .in_pix   (wrap_pix),
    .clearing (clearing),
    .hist     (hist)
  );

  tmb_blend #(
    .FramesAveraged (FRAMES_AVERAGED)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .hist      (hist),
    .out_valid (blend_valid),
    .out_item  (blend_item)
  );

  tmb_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (blend_valid),
    .up_item   (blend_item),
    .up_ready  (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during history clear");

  skid_full_has_output: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && !clearing) |-> out_valid)
    else $error("pipeline stalled with no result waiting");

  clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open right after reset");

  wrap_item_needs_open: assert property (@(posedge clk) disable iff (rst)
    (wrap_valid && !$past(wrap_valid) && !$past(rst)) |-> $past(adv))
    else $error("item entered the pipeline without advance");

endmodule
